// ===== hdl/drm_pkg.sv =====
package drm_pkg;

	// Default sizes of the region list
	localparam int MAX_REGIONS_DEF = 3;
	localparam int STORE_DEPTH_DEF = 4;
	localparam int MAX_RESULTS     = 3;

	localparam logic [14:0] DIM_MAX = 15'h7fff;

	// Item opcodes
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Merge pass selection
	localparam logic M_OVL = 1'b0;
	localparam logic M_WST = 1'b1;

	typedef struct packed {
		logic signed [14:0] x;
		logic signed [14:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} box_t;

	typedef struct packed {
		box_t        box;
		logic [29:0] area;
	} entry_t;

	// Shared unit commands
	typedef enum logic [2:0] {
		UC_IDLE  = 3'd0,
		UC_GEO   = 3'd1,
		UC_MBOX  = 3'd2,
		UC_MOVL  = 3'd3,
		UC_MRECT = 3'd4
	} unit_cmd_t;

	// Results of the shared unit
	typedef struct packed {
		box_t        box;
		logic        ovok;
		logic [30:0] sum;
		logic [29:0] prod;
	} unit_res_t;

endpackage

// ===== hdl/drm_store.sv =====
module drm_store #(
	parameter int DEPTH = drm_pkg::STORE_DEPTH_DEF,
	parameter int IW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IW-1:0]    waddr,
	input  drm_pkg::entry_t  wdata,
	input  logic [IW-1:0]    raddr_a,
	input  logic [IW-1:0]    raddr_b,
	output drm_pkg::entry_t  rdata_a,
	output drm_pkg::entry_t  rdata_b
);
	import drm_pkg::*;

	entry_t mem [DEPTH];

	// Write one entry, read two with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== hdl/drm_unit.sv =====
module drm_unit (
	input  logic                 clk,
	input  drm_pkg::unit_cmd_t   cmd,
	input  drm_pkg::entry_t      ent_a,
	input  drm_pkg::entry_t      ent_b,
	input  drm_pkg::box_t        rect,
	output drm_pkg::unit_res_t   res
);
	import drm_pkg::*;

	logic signed [17:0] xa, xb, ya, yb, ra, rb, da, db;
	logic signed [17:0] lx, ty, rx, dy, dw, dh;
	logic signed [17:0] ox0, ox1, oy0, oy1, odw, odh;
	logic [14:0]        bw, bh, ow_q, oh_q, ma, mb;
	logic [29:0]        prod_d;

	// Edges of both entries
	always_comb begin
		xa = 18'(ent_a.box.x);
		xb = 18'(ent_b.box.x);
		ya = 18'(ent_a.box.y);
		yb = 18'(ent_b.box.y);
		ra = xa + 18'(signed'({1'b0, ent_a.box.w}));
		rb = xb + 18'(signed'({1'b0, ent_b.box.w}));
		da = ya + 18'(signed'({1'b0, ent_a.box.h}));
		db = yb + 18'(signed'({1'b0, ent_b.box.h}));
		// Bounding box, saturated
		lx = (xa < xb) ? xa : xb;
		ty = (ya < yb) ? ya : yb;
		rx = (ra > rb) ? ra : rb;
		dy = (da > db) ? da : db;
		dw = rx - lx;
		dh = dy - ty;
		bw = (dw > 18'sd32767) ? DIM_MAX : dw[14:0];
		bh = (dh > 18'sd32767) ? DIM_MAX : dh[14:0];
		// Intersection
		ox0 = (xa > xb) ? xa : xb;
		ox1 = (ra < rb) ? ra : rb;
		oy0 = (ya > yb) ? ya : yb;
		oy1 = (da < db) ? da : db;
		odw = ox1 - ox0;
		odh = oy1 - oy0;
	end

	// Select multiplier operands
	always_comb begin
		case (cmd)
			UC_MBOX: begin
				ma = res.box.w;
				mb = res.box.h;
			end
			UC_MOVL: begin
				ma = ow_q;
				mb = oh_q;
			end
			UC_MRECT: begin
				ma = rect.w;
				mb = rect.h;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod_d = ma * mb;

	// Register geometry and product
	always_ff @(posedge clk) begin
		if (cmd == UC_GEO) begin
			res.box.x <= lx[14:0];
			res.box.y <= ty[14:0];
			res.box.w <= bw;
			res.box.h <= bh;
			res.ovok  <= !(ox0 > ox1) && !(oy0 > oy1);
			res.sum   <= {1'b0, ent_a.area} + {1'b0, ent_b.area};
			ow_q      <= odw[14:0];
			oh_q      <= odh[14:0];
		end
		if (cmd == UC_MBOX || cmd == UC_MOVL || cmd == UC_MRECT) begin
			res.prod <= prod_d;
		end
	end

endmodule

// ===== hdl/dirty_rect_merge_list.sv =====
// An add is appended (APP, AWR); each scan steps every entry pair through RD, GEO,
// MB, MO, EV; each merge runs MRD, MGEO, MMB, MWR and compacts via CRD, CWR per
// entry. A clear or an add to a full list goes straight to reporting: each region
// passes ORD, OLD, OUT, an empty list ORD, OUT, plus any output stall. Throughput:
// one item at a time; the next may be taken in the cycle after the last result
// transfer. Reset: asynchronous active-low reset empties the list.
module dirty_rect_merge_list #(
	parameter int MAX_REGIONS = drm_pkg::MAX_REGIONS_DEF,
	parameter int STORE_DEPTH = drm_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [14:0] rect_x,
	input  logic [14:0] rect_y,
	input  logic [14:0] rect_w,
	input  logic [14:0] rect_h,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [14:0] out_x,
	output logic [14:0] out_y,
	output logic [14:0] out_w,
	output logic [14:0] out_h,
	output logic        out_valid,
	output logic [2:0]  region_count,
	output logic        last
);
	import drm_pkg::*;

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_APP  = 18'h00002,
		S_AWR  = 18'h00004,
		S_DEC  = 18'h00008,
		S_RD   = 18'h00010,
		S_GEO  = 18'h00020,
		S_MB   = 18'h00040,
		S_MO   = 18'h00080,
		S_EV   = 18'h00100,
		S_MRD  = 18'h00200,
		S_MGEO = 18'h00400,
		S_MMB  = 18'h00800,
		S_MWR  = 18'h01000,
		S_CRD  = 18'h02000,
		S_CWR  = 18'h04000,
		S_ORD  = 18'h08000,
		S_OLD  = 18'h10000,
		S_OUT  = 18'h20000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic               mode_q;
	logic [IW-1:0]      pi_q, pj_q, bi_q, bj_q, r_q, k_q;
	logic [CW-1:0]      w_q;
	logic               found_q;
	logic [29:0]        best_ovl_q, union_q, cand;
	logic signed [31:0] best_wst_q, waste;
	logic               row_end, scan_end, keep, ilast;
	box_t               rect_q;

	logic               we;
	logic [IW-1:0]      waddr, raddr_a, raddr_b;
	entry_t             wdata, rdata_a, rdata_b;
	unit_cmd_t          cmd;
	unit_res_t          ures;

	drm_store #(.DEPTH(STORE_DEPTH), .IW(IW)) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	drm_unit u_unit (
		.clk   (clk),
		.cmd   (cmd),
		.ent_a (rdata_a),
		.ent_b (rdata_b),
		.rect  (rect_q),
		.res   (ures)
	);

	assign in_stall  = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);

	// Drive store ports and unit command
	always_comb begin
		we      = 1'b0;
		waddr   = count_q[IW-1:0];
		wdata   = {rect_q, ures.prod};
		raddr_a = pi_q;
		raddr_b = pj_q;
		cmd     = UC_IDLE;
		case (state_q)
			S_APP:  cmd = UC_MRECT;
			S_AWR:  we = 1'b1;
			S_GEO:  cmd = UC_GEO;
			S_MB:   cmd = UC_MBOX;
			S_MO:   cmd = UC_MOVL;
			S_MRD: begin
				raddr_a = bi_q;
				raddr_b = bj_q;
			end
			S_MGEO: cmd = UC_GEO;
			S_MMB:  cmd = UC_MBOX;
			S_MWR: begin
				we    = 1'b1;
				waddr = bi_q;
				wdata = {ures.box, ures.prod};
			end
			S_CRD:  raddr_a = r_q;
			S_CWR: begin
				we    = keep;
				waddr = w_q[IW-1:0];
				wdata = rdata_a;
			end
			S_ORD:  raddr_a = k_q;
			default: ;
		endcase
	end

	// Pair scoring and scan position
	always_comb begin
		cand     = ({1'b0, union_q} < ures.sum && ures.ovok) ? ures.prod : '0;
		waste    = $signed({2'b0, union_q}) - $signed({1'b0, ures.sum});
		row_end  = (CW'(pj_q) == count_q - 1'b1);
		scan_end = row_end && (CW'(pi_q) == count_q - 2'd2);
		keep     = (r_q != bj_q) && (rdata_a.area != '0);
		ilast    = (32'(k_q) + 1 == 32'(count_q)) || (32'(k_q) + 1 == MAX_RESULTS);
	end

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mode_q  <= M_OVL;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_CLEAR) begin
							count_q <= '0;
							state_q <= S_ORD;
						end else if (count_q == CW'(STORE_DEPTH)) begin
							state_q <= S_ORD;
						end else begin
							state_q <= S_APP;
						end
					end
				end
				S_APP:  state_q <= S_AWR;
				S_AWR: begin
					count_q <= count_q + 1'b1;
					mode_q  <= M_OVL;
					state_q <= S_DEC;
				end
				S_DEC: begin
					if (mode_q == M_OVL && count_q >= CW'(2)) begin
						state_q <= S_RD;
					end else if (32'(count_q) > MAX_REGIONS && count_q > CW'(1)) begin
						mode_q  <= M_WST;
						state_q <= S_RD;
					end else begin
						state_q <= S_ORD;
					end
				end
				S_RD:   state_q <= S_GEO;
				S_GEO:  state_q <= S_MB;
				S_MB:   state_q <= S_MO;
				S_MO:   state_q <= S_EV;
				S_EV: begin
					if (!scan_end) begin
						state_q <= S_RD;
					end else if (mode_q == M_WST) begin
						state_q <= S_MRD;
					end else if (found_q || cand > best_ovl_q) begin
						state_q <= S_MRD;
					end else begin
						mode_q  <= M_WST;
						state_q <= S_DEC;
					end
				end
				S_MRD:  state_q <= S_MGEO;
				S_MGEO: state_q <= S_MMB;
				S_MMB:  state_q <= S_MWR;
				S_MWR:  state_q <= S_CRD;
				S_CRD:  state_q <= S_CWR;
				S_CWR: begin
					if (CW'(r_q) == count_q - 1'b1) begin
						count_q <= w_q + CW'(keep);
						state_q <= S_DEC;
					end else begin
						state_q <= S_CRD;
					end
				end
				S_ORD:  state_q <= (count_q == '0) ? S_OUT : S_OLD;
				S_OLD:  state_q <= S_OUT;
				S_OUT: begin
					if (!res_stall) begin
						state_q <= last ? S_IDLE : S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				rect_q <= {rect_x, rect_y, rect_w, rect_h};
				k_q    <= '0;
			end
			S_DEC: begin
				// start a scan at the first pair
				pi_q       <= '0;
				pj_q       <= IW'(1);
				found_q    <= 1'b0;
				best_ovl_q <= '0;
				best_wst_q <= '0;
				bi_q       <= '0;
				bj_q       <= '0;
				k_q        <= '0;
			end
			S_MO: union_q <= ures.prod;
			S_EV: begin
				if (mode_q == M_OVL) begin
					if (cand > best_ovl_q) begin
						best_ovl_q <= cand;
						found_q    <= 1'b1;
						bi_q       <= pi_q;
						bj_q       <= pj_q;
					end
				end else if (!found_q || waste < best_wst_q) begin
					best_wst_q <= waste;
					found_q    <= 1'b1;
					bi_q       <= pi_q;
					bj_q       <= pj_q;
				end
				// advance to the next pair
				if (row_end) begin
					pi_q <= pi_q + 1'b1;
					pj_q <= pi_q + 1'b1 + 1'b1;
				end else begin
					pj_q <= pj_q + 1'b1;
				end
			end
			S_MWR: begin
				r_q <= '0;
				w_q <= '0;
			end
			S_CWR: begin
				// compact: drop the merged partner and empty entries
				if (keep) begin
					w_q <= w_q + 1'b1;
				end
				r_q <= r_q + 1'b1;
			end
			S_ORD: begin
				if (count_q == '0) begin
					out_x        <= '0;
					out_y        <= '0;
					out_w        <= '0;
					out_h        <= '0;
					out_valid    <= 1'b0;
					region_count <= '0;
					last         <= 1'b1;
				end
			end
			S_OLD: begin
				out_x        <= rdata_a.box.x;
				out_y        <= rdata_a.box.y;
				out_w        <= rdata_a.box.w;
				out_h        <= rdata_a.box.h;
				out_valid    <= 1'b1;
				region_count <= 3'(count_q);
				last         <= ilast;
			end
			S_OUT: begin
				if (!res_stall) begin
					k_q <= k_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== tb/sv/dirty_rect_merge_list_tb.sv =====
`timescale 1ns / 1ps

module dirty_rect_merge_list_tb;
	import drm_pkg::*;

	localparam int LIST_MAX  = MAX_REGIONS_DEF;
	localparam int LIST_SLOTS = STORE_DEPTH_DEF;
	localparam longint DIM_SAT = 32767;

	typedef struct {
		logic [14:0] x;
		logic [14:0] y;
		logic [14:0] w;
		logic [14:0] h;
		logic        ov;
		logic [2:0]  cnt;
		logic        lst;
	} region_rpt_t;

	// Tracks the region list and the reports still owed by the block
	class region_board;
		longint rx[LIST_SLOTS];
		longint ry[LIST_SLOTS];
		longint rw[LIST_SLOTS];
		longint rh[LIST_SLOTS];
		longint ra[LIST_SLOTS];
		int unsigned held;
		region_rpt_t owed[$];
		int errors;

		function new();
			held = 0;
			errors = 0;
			for (int i = 0; i < LIST_SLOTS; i++) begin
				rx[i] = 0; ry[i] = 0; rw[i] = 0; rh[i] = 0; ra[i] = 0;
			end
		endfunction

		function void bound(int a, int b, output longint x, output longint y,
				output longint w, output longint h);
			longint r;
			longint d;
			x = (rx[a] < rx[b]) ? rx[a] : rx[b];
			y = (ry[a] < ry[b]) ? ry[a] : ry[b];
			r = (rx[a] + rw[a] > rx[b] + rw[b]) ? rx[a] + rw[a] : rx[b] + rw[b];
			d = (ry[a] + rh[a] > ry[b] + rh[b]) ? ry[a] + rh[a] : ry[b] + rh[b];
			w = (r - x > DIM_SAT) ? DIM_SAT : r - x;
			h = (d - y > DIM_SAT) ? DIM_SAT : d - y;
		endfunction

		function longint bound_area(int a, int b);
			longint x, y, w, h;
			bound(a, b, x, y, w, h);
			return w * h;
		endfunction

		function longint shared_area(int a, int b);
			longint x0, x1, y0, y1;
			x0 = (rx[a] > rx[b]) ? rx[a] : rx[b];
			x1 = (rx[a] + rw[a] < rx[b] + rw[b]) ? rx[a] + rw[a] : rx[b] + rw[b];
			if (x0 > x1)
				return 0;
			y0 = (ry[a] > ry[b]) ? ry[a] : ry[b];
			y1 = (ry[a] + rh[a] < ry[b] + rh[b]) ? ry[a] + rh[a] : ry[b] + rh[b];
			if (y0 > y1)
				return 0;
			return (x1 - x0) * (y1 - y0);
		endfunction

		// Fold the higher entry into the lower one, then drop empty entries
		function void fold(int i, int j);
			int p, q, n;
			longint x, y, w, h;
			p = (i < j) ? i : j;
			q = (i < j) ? j : i;
			bound(p, q, x, y, w, h);
			rx[p] = x; ry[p] = y; rw[p] = w; rh[p] = h;
			ra[p] = w * h;
			ra[q] = 0;
			n = 0;
			for (int k = 0; k < held; k++) begin
				if (ra[k] > 0) begin
					rx[n] = rx[k]; ry[n] = ry[k]; rw[n] = rw[k]; rh[n] = rh[k];
					ra[n] = ra[k];
					n++;
				end
			end
			held = n;
		endfunction

		function bit fold_overlap();
			longint best, a;
			int bi, bj;
			best = 0; bi = 0; bj = 0;
			for (int i = 0; i < held; i++)
				for (int j = 0; j < held; j++) begin
					if (i == j)
						continue;
					a = 0;
					if (bound_area(i, j) < ra[i] + ra[j])
						a = shared_area(i, j);
					if (best < a) begin
						best = a; bi = i; bj = j;
					end
				end
			if (best > 0) begin
				fold(bi, bj);
				return 1;
			end
			return 0;
		endfunction

		function void fold_least_waste();
			bit found;
			longint best, wv;
			int bi, bj;
			found = 0; best = 0; bi = 0; bj = 0;
			for (int i = 0; i < held; i++)
				for (int j = 0; j < held; j++) begin
					if (i == j)
						continue;
					wv = bound_area(i, j) - (ra[i] + ra[j]);
					if (!found || wv < best) begin
						found = 1; best = wv; bi = i; bj = j;
					end
				end
			if (found)
				fold(bi, bj);
		endfunction

		// Update the list for one accepted transfer and queue its reports
		function void note_item(logic op, logic [14:0] x, logic [14:0] y,
				logic [14:0] w, logic [14:0] h);
			region_rpt_t r;
			int n;
			if (op == OP_CLEAR) begin
				held = 0;
			end else if (held < LIST_SLOTS) begin
				rx[held] = longint'($signed(x));
				ry[held] = longint'($signed(y));
				rw[held] = longint'(w);
				rh[held] = longint'(h);
				ra[held] = rw[held] * rh[held];
				held++;
				if (held > 1) begin
					while (fold_overlap())
						;
					while (held > LIST_MAX && held > 1)
						fold_least_waste();
				end
			end
			if (held == 0) begin
				r = '{x: 0, y: 0, w: 0, h: 0, ov: 0, cnt: 0, lst: 1};
				owed.push_back(r);
				return;
			end
			n = (held < MAX_RESULTS) ? held : MAX_RESULTS;
			for (int k = 0; k < n; k++) begin
				r.x = rx[k][14:0];
				r.y = ry[k][14:0];
				r.w = rw[k][14:0];
				r.h = rh[k][14:0];
				r.ov = 1;
				r.cnt = held[2:0];
				r.lst = (k + 1 == n);
				owed.push_back(r);
			end
		endfunction

		function void field(string nm, longint e, longint a);
			if (e != a) begin
				errors++;
				if (errors < 60)
					$display("%0t %s expected %0h actual %0h", $time, nm, e, a);
			end
		endfunction

		function void check_report(region_rpt_t got);
			region_rpt_t e;
			if (owed.size() == 0) begin
				errors++;
				if (errors < 60)
					$display("%0t unexpected region transfer x %0h", $time, got.x);
				return;
			end
			e = owed.pop_front();
			field("out_x", e.x, got.x);
			field("out_y", e.y, got.y);
			field("out_w", e.w, got.w);
			field("out_h", e.h, got.h);
			field("out_valid", e.ov, got.ov);
			field("region_count", e.cnt, got.cnt);
			field("last", e.lst, got.lst);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic        opcode = 0;
	logic [14:0] rect_x = 0;
	logic [14:0] rect_y = 0;
	logic [14:0] rect_w = 0;
	logic [14:0] rect_h = 0;
	logic        res_valid;
	logic        res_stall = 0;
	logic [14:0] out_x;
	logic [14:0] out_y;
	logic [14:0] out_w;
	logic [14:0] out_h;
	logic        out_valid;
	logic [2:0]  region_count;
	logic        last;

	region_board board = new();
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	dirty_rect_merge_list u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .rect_x(rect_x), .rect_y(rect_y),
		.rect_w(rect_w), .rect_h(rect_h),
		.res_valid(res_valid), .res_stall(res_stall),
		.out_x(out_x), .out_y(out_y), .out_w(out_w), .out_h(out_h),
		.out_valid(out_valid), .region_count(region_count), .last(last)
	);

	always #10 clk = ~clk;

	// Check each result transfer
	always @(posedge clk) begin
		region_rpt_t got;
		if (arst_n && res_valid && !res_stall) begin
			got.x = out_x; got.y = out_y; got.w = out_w; got.h = out_h;
			got.ov = out_valid; got.cnt = region_count; got.lst = last;
			board.check_report(got);
		end
	end

	// Pick the next stall, counting down a long hold-off when requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1;
		end else begin
			res_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Offer one item and hold it until the transfer, then idle at random
	task send_item(logic op, logic [14:0] x, logic [14:0] y, logic [14:0] w,
			logic [14:0] h);
		in_valid <= 1;
		opcode <= op; rect_x <= x; rect_y <= y; rect_w <= w; rect_h <= h;
		do
			@(posedge clk);
		while (in_stall);
		board.note_item(op, x, y, w, h);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	task add_rect(int x, int y, int w, int h);
		send_item(OP_ADD, x[14:0], y[14:0], w[14:0], h[14:0]);
	endtask

	task wait_drained();
		in_valid <= 0;
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Mostly clustered rectangles that overlap, some clears and raw noise
	task random_item();
		int sel, c, x, y;
		sel = $urandom_range(99);
		if (sel < 8) begin
			send_item(OP_CLEAR, 15'($urandom), 15'($urandom), 15'($urandom),
				15'($urandom));
		end else if (sel < 20) begin
			send_item(OP_ADD, 15'($urandom), 15'($urandom), 15'($urandom),
				15'($urandom));
		end else begin
			c = $urandom_range(400);
			x = c + $urandom_range(120) - 60;
			y = c + $urandom_range(120) - 60;
			if ($urandom_range(9) == 0)
				add_rect(x, y, 0, $urandom_range(80));
			else
				add_rect(x, y, $urandom_range(1, 100), $urandom_range(1, 100));
		end
	endtask

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: empty list, zero area, overlap, waste merge, extremes
		send_item(OP_CLEAR, 15'h7fff, 15'd0, 15'h7fff, 15'd0);
		add_rect(0, 0, 0, 0);
		add_rect(0, 0, 10, 10);
		add_rect(5, 5, 10, 10);
		add_rect(100, 100, 10, 10);
		add_rect(300, 300, 10, 10);
		add_rect(-200, -200, 5, 5);
		add_rect(1000, 1000, 1, 1);
		send_item(OP_CLEAR, 15'd0, 15'd0, 15'd0, 15'd0);
		add_rect(-16384, -16384, 32767, 32767);
		add_rect(16383, 16383, 16384, 16384);
		add_rect(0, 0, 16384, 16384);
		send_item(OP_CLEAR, 15'd0, 15'd0, 15'd0, 15'd0);
		add_rect(-16384, 0, 16384, 1);
		add_rect(16383, 0, 16384, 1);
		add_rect(0, -16384, 1, 32767);
		add_rect(16383, 16383, 0, 0);
		add_rect(10, 10, 20, 20);
		add_rect(15, 15, 20, 20);
		add_rect(10, 10, 20, 20);
		send_item(OP_CLEAR, 15'd0, 15'd0, 15'd0, 15'd0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			// Long receiver hold-off while items keep coming
			if (ph == 3)
				hold_req = 400;
			for (int n = 0; n < 85; n++)
				random_item();
			wait_drained();
		end

		if (board.errors == 0 && board.owed.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/drm_pkg.sv
hdl/drm_store.sv
hdl/drm_unit.sv
hdl/dirty_rect_merge_list.sv
tb/sv/dirty_rect_merge_list_tb.sv
